[sv/salc_pkg.sv]
// salc_pkg: shared types and constants for the set-associative lru cache model
// no dependencies

package salc_pkg;

  localparam logic [1:0] KIND_INSTR  = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_STORE  = 2'd2;
  localparam logic [1:0] KIND_MODIFY = 2'd3;

  localparam logic [1:0] OUT_NONE  = 2'd0;
  localparam logic [1:0] OUT_HIT   = 2'd1;
  localparam logic [1:0] OUT_MISS  = 2'd2;
  localparam logic [1:0] OUT_EVICT = 2'd3;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam int AGE_W = 3;
  localparam logic [AGE_W-1:0] AGE_TOP = 3'd7;
  localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
  } salc_in_t;

  typedef struct packed {
    logic [1:0]  first_outcome;
    logic        second_hit;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
  } salc_out_t;

endpackage

[sv/salc_if.sv]
// salc_if: valid/ready channel interfaces for input records and results
// depends on salc_pkg

interface salc_in_if import salc_pkg::*; ();
  logic     valid;
  logic     ready;
  salc_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface salc_out_if import salc_pkg::*; ();
  logic      valid;
  logic      ready;
  salc_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/salc_front.sv]
// salc_front: accepts trace records, splits address into set and tag, queues work
// depends on salc_pkg

module salc_front import salc_pkg::*; #(
  parameter int SET_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  salc_in_t          in_data,
  input  logic [2:0]        set_bits,
  input  logic [5:0]        block_bits,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [1:0]        q_kind,
  output logic [SET_W-1:0]  q_set,
  output logic [63:0]       q_tag
);

  localparam int QD = 2;

  logic [1:0]       kind_q [QD];
  logic [SET_W-1:0] set_q  [QD];
  logic [63:0]      tag_q  [QD];
  logic [1:0]       count;
  logic             wr_ptr, rd_ptr;
  logic [2:0]       s_eff;
  logic [6:0]       shift;
  logic [63:0]      shifted, set_mask;
  logic [SET_W-1:0] set_idx;
  logic [63:0]      tag;
  logic             push, pop;

  always_comb begin
    s_eff = (32'(set_bits) > SET_W) ? 3'(SET_W) : set_bits;
    shift = 7'(block_bits) + 7'(s_eff);
    shifted = in_data.address >> block_bits;
    set_mask = (64'd1 << s_eff) - 64'd1;
    set_idx = SET_W'(shifted & set_mask);
    tag = shift[6] ? 64'd0 : (in_data.address >> shift[5:0]);
  end

  assign in_ready = (count != 2'(QD));
  assign q_valid  = (count != 2'd0);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_kind = kind_q[rd_ptr];
  assign q_set  = set_q[rd_ptr];
  assign q_tag  = tag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      kind_q[wr_ptr] <= in_data.kind;
      set_q[wr_ptr]  <= set_idx;
      tag_q[wr_ptr]  <= tag;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(QD))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1) else $error("queue count slip");

endmodule

[sv/salc_back.sv]
// salc_back: per-set lookup, lru update and counters; up to two accesses per record
// depends on salc_pkg

module salc_back import salc_pkg::*; #(
  parameter int SET_W = 6,
  parameter int WAYS  = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       ways_in_use,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [1:0]       q_kind,
  input  logic [SET_W-1:0] q_set,
  input  logic [63:0]      q_tag,
  output logic             out_valid,
  input  logic             out_ready,
  output salc_out_t        out_data
);

  localparam int SETS = 1 << SET_W;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WC_W = $clog2(WAYS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_SECND = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // set rows: at most one row read into registers and one row written back per cycle
  logic [WAYS-1:0]       valid_mem [SETS];
  logic [AGE_W-1:0]      age_mem   [SETS][WAYS];
  logic [63:0]           tag_mem   [SETS][WAYS];

  logic [1:0]            state;
  logic                  clearing;
  logic [SET_W-1:0]      clr_idx;
  logic [1:0]            kind;
  logic [SET_W-1:0]      set_idx;
  logic [63:0]           tag;
  logic [WAYS-1:0]       row_valid, valid_next;
  logic [AGE_W-1:0]      row_age  [WAYS];
  logic [AGE_W-1:0]      age_next [WAYS];
  logic [63:0]           row_tag  [WAYS];
  logic [63:0]           tag_next [WAYS];
  logic [31:0]           hits, misses, evicts;
  logic [1:0]            first;
  logic                  second;
  logic                  access;

  logic [WC_W-1:0]       ways_eff;
  logic [WAYS-1:0]       use_m, hit_m;
  logic                  any_hit, any_empty;
  logic [WAY_W-1:0]      hit_w, empty_w, vict_w, sel_w;
  logic [AGE_W-1:0]      top_age, limit;
  logic [AGE_W:0]        limit_x;
  logic [1:0]            res;

  always_comb begin
    if (ways_in_use == 4'd0) ways_eff = WC_W'(1);
    else if (32'(ways_in_use) > WAYS) ways_eff = WC_W'(WAYS);
    else ways_eff = WC_W'(ways_in_use);
    any_hit = 1'b0; any_empty = 1'b0;
    hit_w = '0; empty_w = '0; vict_w = '0;
    top_age = row_age[0];
    for (int w = 0; w < WAYS; w++) begin
      use_m[w] = (w < 32'(ways_eff));
      hit_m[w] = use_m[w] && row_valid[w] && (row_tag[w] == tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_m[w]) begin any_hit = 1'b1; hit_w = WAY_W'(w); end
      if (use_m[w] && !row_valid[w]) begin
        any_empty = 1'b1; empty_w = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (use_m[w] && row_age[w] > top_age) begin
        top_age = row_age[w]; vict_w = WAY_W'(w);
      end
    end
    if (any_hit) begin
      res = OUT_HIT; sel_w = hit_w; limit_x = {1'b0, row_age[hit_w]};
    end else if (any_empty) begin
      res = OUT_MISS; sel_w = empty_w; limit_x = {1'b1, {AGE_W{1'b0}}};
    end else begin
      res = OUT_EVICT; sel_w = vict_w; limit_x = {1'b0, top_age};
    end
    limit = limit_x[AGE_W-1:0];
    // next row: selected way becomes youngest, younger valid ways age by one
    for (int w = 0; w < WAYS; w++) begin
      age_next[w] = row_age[w];
      tag_next[w] = row_tag[w];
      if (WAY_W'(w) == sel_w) begin
        age_next[w] = '0;
        tag_next[w] = tag;
      end else if (use_m[w] && row_valid[w] && (limit_x[AGE_W] ||
                   row_age[w] < limit) && row_age[w] != AGE_TOP) begin
        age_next[w] = row_age[w] + AGE_W'(1);
      end
    end
    valid_next = row_valid;
    valid_next[sel_w] = 1'b1;
  end

  assign access    = (state == ST_FIRST) || (state == ST_SECND);
  assign q_ready   = (state == ST_IDLE) && !clearing;
  assign out_valid = (state == ST_DONE);
  assign out_data  = '{first_outcome: first, second_hit: second,
                       hit_count: hits, miss_count: misses, eviction_count: evicts};

  // row memories: clearing sweep after reset, else write-back of the updated row
  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_idx] <= '0;
      for (int w = 0; w < WAYS; w++) age_mem[clr_idx][w] <= '0;
    end else if (access) begin
      valid_mem[set_idx] <= valid_next;
      for (int w = 0; w < WAYS; w++) begin
        age_mem[set_idx][w] <= age_next[w];
        tag_mem[set_idx][w] <= tag_next[w];
      end
    end
  end

  // row registers: loaded on transfer from the queue, updated per access
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      row_valid <= valid_mem[q_set];
      for (int w = 0; w < WAYS; w++) begin
        row_age[w] <= age_mem[q_set][w];
        row_tag[w] <= tag_mem[q_set][w];
      end
    end else if (access) begin
      row_valid <= valid_next;
      for (int w = 0; w < WAYS; w++) begin
        row_age[w] <= age_next[w];
        row_tag[w] <= tag_next[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clearing <= 1'b1;
      clr_idx <= '0;
      hits <= '0; misses <= '0; evicts <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + SET_W'(1);
        if (clr_idx == SET_W'(SETS - 1)) clearing <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (q_valid && q_ready) begin
          kind <= q_kind; set_idx <= q_set; tag <= q_tag;
          first <= OUT_NONE; second <= 1'b0;
          state <= (q_kind == KIND_INSTR) ? ST_DONE : ST_FIRST;
        end
        ST_FIRST, ST_SECND: begin
          if (res == OUT_HIT) begin
            if (hits != COUNT_TOP) hits <= hits + 32'd1;
          end else if (misses != COUNT_TOP) misses <= misses + 32'd1;
          if (res == OUT_EVICT && evicts != COUNT_TOP) evicts <= evicts + 32'd1;
          if (state == ST_FIRST) begin
            first <= res;
            state <= (kind == KIND_MODIFY) ? ST_SECND : ST_DONE;
          end else begin
            second <= (res == OUT_HIT);
            state <= ST_DONE;
          end
        end
        ST_DONE: if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SECND) |-> kind == KIND_MODIFY) else $error("second access without modify");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SECND) |-> res == OUT_HIT) else $error("modify second access missed");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(hits)) else $error("count moved while held");

endmodule

[sv/set_assoc_lru_cache_sim_top.sv]
// set_assoc_lru_cache_sim_top: records go through a two-entry queue into a back end that
// reads the set row, makes one access per cycle and writes the row back
// the back end takes a new record only once the last result is taken
// accesses per record: none for a fetch, one for a load or store, two for a modify
// reset is synchronous: counts clear at once, then a sweep over all 2**MAX_SET_BITS sets
// (64 by default) clears valid bits and ages; the back end takes no records during it
// depends on salc_pkg, salc_if, salc_front, salc_back

module set_assoc_lru_cache_sim_top import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input logic             clk,
  input logic             rst,
  salc_in_if.sink         in_ch,
  salc_out_if.source      out_ch,
  input logic             cfg_we,
  input logic [1:0]       cfg_index,
  input logic [5:0]       cfg_data
);

  // configuration registers
  logic [2:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways_in_use;

  // queue to back end
  logic                    q_valid, q_ready;
  logic [1:0]              q_kind;
  logic [MAX_SET_BITS-1:0] q_set;
  logic [63:0]             q_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= 3'd4;
      block_bits <= 6'd4;
      ways_in_use <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:   set_bits <= cfg_data[2:0];
        REG_BLOCK_BITS: block_bits <= cfg_data;
        REG_WAYS:       ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // front end: address split and transfer into the queue
  salc_front #(.SET_W(MAX_SET_BITS)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.payload),
    .set_bits, .block_bits,
    .q_valid, .q_ready, .q_kind, .q_set, .q_tag
  );

  // back end: lookup, replacement and counters
  salc_back #(.SET_W(MAX_SET_BITS), .WAYS(MAX_WAYS)) u_back (
    .clk, .rst, .ways_in_use,
    .q_valid, .q_ready, .q_kind, .q_set, .q_tag,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.payload)
  );

endmodule
